// File: rtl/interval_lane_allocator_defines.svh
// Assertion macros shared by the lane allocator RTL.
`ifndef INTERVAL_LANE_ALLOCATOR_DEFINES_SVH
`define INTERVAL_LANE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ILA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ila assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ILA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ila assertion failed");

`endif

// File: rtl/ila_pkg.sv
`timescale 1ns / 1ps
package ila_pkg;

    localparam int MAX_LANES_DEF = 32;

    localparam int DEV_W     = 8;
    localparam int STRM_W    = 16;
    localparam int KEY_W     = DEV_W + STRM_W;
    localparam int TIME_W    = 63;
    localparam int LANE_IDX_W = 5;
    localparam int TID_W     = 16;

    localparam logic [TID_W-1:0] TID_FIRST = 16'h0001;
    localparam logic [TID_W-1:0] TID_LAST  = 16'hFFFF;

endpackage

// File: rtl/ila_if.sv
`timescale 1ns / 1ps
interface ila_in_if;
    logic                           valid;
    logic                           ready;
    logic [ila_pkg::DEV_W-1:0]      device_id;
    logic [ila_pkg::STRM_W-1:0]     stream_id;
    logic [ila_pkg::TIME_W-1:0]     start_time;
    logic [ila_pkg::TIME_W-1:0]     end_time;

    modport source (output valid, device_id, stream_id, start_time, end_time,
                    input ready);
    modport sink   (input valid, device_id, stream_id, start_time, end_time,
                    output ready);
endinterface

interface ila_out_if;
    logic                           valid;
    logic                           ready;
    logic [ila_pkg::LANE_IDX_W-1:0] lane_index;
    logic [ila_pkg::TID_W-1:0]      lane_thread_id;
    logic                           new_lane;
    logic                           overflow;

    modport source (output valid, lane_index, lane_thread_id, new_lane, overflow,
                    input ready);
    modport sink   (input valid, lane_index, lane_thread_id, new_lane, overflow,
                    output ready);
endinterface

// File: rtl/ila_ram.sv
`timescale 1ns / 1ps
module ila_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/interval_lane_allocator.sv
// Lane allocator, one transaction in flight. An input transaction is taken in IDLE,
// each open lane of its group is read from the lane RAM and compared in SCAN, and the
// result is registered in DONE; the next input is taken only back in IDLE, and a
// waiting result that is not yet taken holds the block in DONE.
// Reset (synchronous, active low) clears busy bits, counters and group at once;
// lane end/thread RAM is not cleared and is read only for lanes already opened.
`timescale 1ns / 1ps
`include "interval_lane_allocator_defines.svh"
module interval_lane_allocator #(
    parameter int MAX_LANES = ila_pkg::MAX_LANES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ila_in_if.sink     i_in,
    ila_out_if.source  o_out
);
    localparam int IW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int CW = $clog2(MAX_LANES + 1);
    localparam int RW = ila_pkg::TIME_W + ila_pkg::TID_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                        r_state;
    logic [MAX_LANES-1:0]          r_busy;
    logic [CW-1:0]                 r_open;
    logic [CW-1:0]                 r_idx;
    logic [ila_pkg::TID_W-1:0]     r_next_tid;
    logic [ila_pkg::KEY_W-1:0]     r_group;
    logic                          r_group_vld;
    logic [ila_pkg::TIME_W-1:0]    r_start;
    logic [ila_pkg::TIME_W-1:0]    r_end;
    logic                          r_cmp_v;
    logic [IW-1:0]                 r_cidx;
    logic                          r_found;
    logic [IW-1:0]                 r_pick;
    logic [ila_pkg::TID_W-1:0]     r_ptid;

    logic                          r_ov;
    logic [ila_pkg::LANE_IDX_W-1:0] r_o_idx;
    logic [ila_pkg::TID_W-1:0]     r_o_tid;
    logic                          r_o_new;
    logic                          r_o_ovf;

    logic [ila_pkg::KEY_W-1:0]     in_key;
    logic                          in_take;
    logic                          issue;
    logic [RW-1:0]                 ram_rdata;
    logic [ila_pkg::TIME_W-1:0]    rd_end;
    logic [ila_pkg::TID_W-1:0]     rd_tid;
    logic                          cmp_free;
    logic                          out_free;
    logic                          done_load;
    logic                          full;
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [RW-1:0]                 ram_wdata;
    logic [ila_pkg::TID_W-1:0]     n_next_tid;

    assign in_key    = {i_in.device_id, i_in.stream_id};
    assign i_in.ready = (r_state == S_IDLE);
    assign in_take   = i_in.valid && (r_state == S_IDLE);

    assign issue     = (r_state == S_SCAN) && (r_idx < r_open);
    assign rd_end    = ram_rdata[RW-1:ila_pkg::TID_W];
    assign rd_tid    = ram_rdata[ila_pkg::TID_W-1:0];
    // a lane is free if idle already or its interval ends at or before this start
    assign cmp_free  = !r_busy[r_cidx] || (rd_end <= r_start);

    assign out_free  = !r_ov || o_out.ready;
    assign done_load = (r_state == S_DONE) && out_free;
    assign full      = (r_open == CW'(MAX_LANES));

    assign n_next_tid = (r_next_tid == ila_pkg::TID_LAST) ? ila_pkg::TID_FIRST
                                                          : r_next_tid + 1'b1;

    assign ram_we    = done_load && (r_found || !full);
    assign ram_waddr = r_found ? r_pick : r_open[IW-1:0];
    assign ram_wdata = {r_end, (r_found ? r_ptid : r_next_tid)};

    ila_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LANES)
    ) u_lane_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_open      <= '0;
            r_idx       <= '0;
            r_next_tid  <= ila_pkg::TID_FIRST;
            r_group     <= '0;
            r_group_vld <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_cmp_v <= issue;
            if (r_ov && o_out.ready && !done_load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_start <= i_in.start_time;
                        r_end   <= i_in.end_time;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (!r_group_vld || (in_key != r_group)) begin
                            r_busy      <= '0;
                            r_open      <= '0;
                            r_group     <= in_key;
                            r_group_vld <= 1'b1;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_idx  <= r_idx + 1'b1;
                        r_cidx <= r_idx[IW-1:0];
                    end
                    if (r_cmp_v && cmp_free) begin
                        r_busy[r_cidx] <= 1'b0;
                        if (!r_found) begin
                            r_found <= 1'b1;
                            r_pick  <= r_cidx;
                            r_ptid  <= rd_tid;
                        end
                    end
                    if (!issue && !r_cmp_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        if (r_found) begin
                            r_o_idx        <= ila_pkg::LANE_IDX_W'(r_pick);
                            r_o_tid        <= r_ptid;
                            r_o_new        <= 1'b0;
                            r_o_ovf        <= 1'b0;
                            r_busy[r_pick] <= 1'b1;
                        end else if (full) begin
                            r_o_idx <= '0;
                            r_o_tid <= '0;
                            r_o_new <= 1'b0;
                            r_o_ovf <= 1'b1;
                        end else begin
                            r_o_idx                <= ila_pkg::LANE_IDX_W'(r_open);
                            r_o_tid                <= r_next_tid;
                            r_o_new                <= 1'b1;
                            r_o_ovf                <= 1'b0;
                            r_busy[r_open[IW-1:0]] <= 1'b1;
                            r_open                 <= r_open + 1'b1;
                            r_next_tid             <= n_next_tid;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.lane_index     = r_o_idx;
    assign o_out.lane_thread_id = r_o_tid;
    assign o_out.new_lane       = r_o_new;
    assign o_out.overflow       = r_o_ovf;

    `ILA_ASSERT_IMP(a_open_bound, i_clk, i_rst_n, 1'b1, r_open <= CW'(MAX_LANES))
    `ILA_ASSERT_IMP(a_pick_open, i_clk, i_rst_n, r_found, CW'(r_pick) < r_open)
    `ILA_ASSERT_NXT(a_tid_adv, i_clk, i_rst_n, ram_we && !r_found, r_next_tid != $past(r_next_tid))
endmodule
